### src/flash_sector_write_back_block_cache_top_macros.svh
// Assertion macros shared by the cache controller modules.
`ifndef FLASH_SECTOR_WRITE_BACK_BLOCK_CACHE_TOP_MACROS_SVH
`define FLASH_SECTOR_WRITE_BACK_BLOCK_CACHE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FSWB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fswb assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define FSWB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fswb assertion failed");

`endif

### src/fswb_pkg.sv
package fswb_pkg;

  localparam int unsigned BLOCK_BYTES_DEF  = 4096;
  localparam int unsigned SECTOR_BYTES_DEF = 512;
  localparam int unsigned PAGE_BYTES_DEF   = 256;

  localparam logic REG_PARTITION_BASE = 1'b0;
  localparam logic REG_SD_BACKED      = 1'b1;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_SYNC  = 2'd2;
  localparam logic [1:0] OP_INVAL = 2'd3;

  typedef logic [3:0] pc_t;

  localparam pc_t PC_INVAL    = 4'd0;
  localparam pc_t PC_BAD      = 4'd1;
  localparam pc_t PC_SYNC     = 4'd2;
  localparam pc_t PC_SYNC_OK  = 4'd3;
  localparam pc_t PC_CARD_RD  = 4'd4;
  localparam pc_t PC_CARD_WR  = 4'd5;
  localparam pc_t PC_READ     = 4'd6;
  localparam pc_t PC_DIRECT   = 4'd7;
  localparam pc_t PC_TOHOST   = 4'd8;
  localparam pc_t PC_WRITE    = 4'd9;
  localparam pc_t PC_WB_CHECK = 4'd10;
  localparam pc_t PC_ERASE    = 4'd11;
  localparam pc_t PC_PROGRAM  = 4'd12;
  localparam pc_t PC_LOAD     = 4'd13;
  localparam pc_t PC_TOCACHE  = 4'd14;
  localparam pc_t PC_LAST     = PC_TOCACHE;

  typedef enum logic [3:0] {
    K_STATUS  = 4'd0,
    K_ERASE   = 4'd1,
    K_PROGRAM = 4'd2,
    K_LOAD    = 4'd3,
    K_DIRECT  = 4'd4,
    K_TOHOST  = 4'd5,
    K_TOCACHE = 4'd6,
    K_CARDRD  = 4'd7,
    K_CARDWR  = 4'd8
  } kind_e;

  typedef enum logic [1:0] {
    D_NO        = 2'd0,
    D_YES       = 2'd1,
    D_SYNC_LAST = 2'd2
  } done_e;

  typedef enum logic [2:0] {
    A_NONE      = 3'd0,
    A_CLR_ALL   = 3'd1,
    A_PAGE_CLR  = 3'd2,
    A_PAGE_INC  = 3'd3,
    A_LOAD_TAG  = 3'd4,
    A_SET_DIRTY = 3'd5
  } act_e;

  typedef enum logic [2:0] {
    J_NEVER     = 3'd0,
    J_HIT       = 3'd1,
    J_CLEAN     = 3'd2,
    J_DIRTY     = 3'd3,
    J_PAGE_MORE = 3'd4
  } cond_e;

  typedef struct packed {
    logic  emit;
    kind_e kind;
    logic  status;
    done_e done_sel;
    act_e  act;
    cond_e jcond;
    pc_t   target;
  } ucode_t;

  typedef struct packed {
    logic  emit;
    kind_e kind;
    logic  status;
    logic  done;
    act_e  act;
  } ctrl_t;

  typedef struct packed {
    logic hit;
    logic dirty;
    logic page_more;
    logic is_sync;
    logic sd;
  } flags_t;

  function automatic ucode_t uc(input logic emit, input kind_e kind, input logic status,
                                input done_e done_sel, input act_e act,
                                input cond_e jcond, input pc_t target);
    ucode_t w;
    w.emit     = emit;
    w.kind     = kind;
    w.status   = status;
    w.done_sel = done_sel;
    w.act      = act;
    w.jcond    = jcond;
    w.target   = target;
    return w;
  endfunction

  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    case (pc)
      PC_INVAL:    w = uc(1'b1, K_STATUS, 1'b0, D_YES, A_CLR_ALL, J_NEVER, PC_INVAL);
      PC_BAD:      w = uc(1'b1, K_STATUS, 1'b1, D_YES, A_NONE, J_NEVER, PC_INVAL);
      PC_SYNC:     w = uc(1'b0, K_STATUS, 1'b0, D_NO, A_NONE, J_DIRTY, PC_ERASE);
      PC_SYNC_OK:  w = uc(1'b1, K_STATUS, 1'b0, D_YES, A_NONE, J_NEVER, PC_INVAL);
      PC_CARD_RD:  w = uc(1'b1, K_CARDRD, 1'b0, D_YES, A_NONE, J_NEVER, PC_INVAL);
      PC_CARD_WR:  w = uc(1'b1, K_CARDWR, 1'b0, D_YES, A_NONE, J_NEVER, PC_INVAL);
      PC_READ:     w = uc(1'b0, K_STATUS, 1'b0, D_NO, A_NONE, J_HIT, PC_TOHOST);
      PC_DIRECT:   w = uc(1'b1, K_DIRECT, 1'b0, D_YES, A_NONE, J_NEVER, PC_INVAL);
      PC_TOHOST:   w = uc(1'b1, K_TOHOST, 1'b0, D_YES, A_NONE, J_NEVER, PC_INVAL);
      PC_WRITE:    w = uc(1'b0, K_STATUS, 1'b0, D_NO, A_NONE, J_HIT, PC_TOCACHE);
      PC_WB_CHECK: w = uc(1'b0, K_STATUS, 1'b0, D_NO, A_NONE, J_CLEAN, PC_LOAD);
      PC_ERASE:    w = uc(1'b1, K_ERASE, 1'b0, D_NO, A_PAGE_CLR, J_NEVER, PC_INVAL);
      PC_PROGRAM:  w = uc(1'b1, K_PROGRAM, 1'b0, D_SYNC_LAST, A_PAGE_INC, J_PAGE_MORE,
                          PC_PROGRAM);
      PC_LOAD:     w = uc(1'b1, K_LOAD, 1'b0, D_NO, A_LOAD_TAG, J_NEVER, PC_INVAL);
      PC_TOCACHE:  w = uc(1'b1, K_TOCACHE, 1'b0, D_YES, A_SET_DIRTY, J_NEVER, PC_INVAL);
      default:     w = uc(1'b1, K_STATUS, 1'b0, D_YES, A_NONE, J_NEVER, PC_INVAL);
    endcase
    return w;
  endfunction

endpackage

### src/fswb_seq.sv
`include "flash_sector_write_back_block_cache_top_macros.svh"

module fswb_seq
  import fswb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] opcode_i,
  input  logic [7:0] drive_number_i,
  input  flags_t     flags_i,
  output logic       busy,
  output ctrl_t      ctrl_o
);

  logic   busy_q, busy_d;
  pc_t    pc_q, pc_d;
  pc_t    entry;
  ucode_t cw;
  logic   jump;
  logic   done_now;

  always_comb begin
    if (opcode_i == OP_INVAL) begin
      entry = PC_INVAL;
    end else if (drive_number_i != 8'd0) begin
      entry = PC_BAD;
    end else if (opcode_i == OP_SYNC) begin
      entry = PC_SYNC;
    end else if (flags_i.sd) begin
      entry = (opcode_i == OP_READ) ? PC_CARD_RD : PC_CARD_WR;
    end else begin
      entry = (opcode_i == OP_READ) ? PC_READ : PC_WRITE;
    end
  end

  assign cw = ucode_rom(pc_q);

  always_comb begin
    case (cw.jcond)
      J_NEVER:     jump = 1'b0;
      J_HIT:       jump = flags_i.hit;
      J_CLEAN:     jump = !flags_i.dirty;
      J_DIRTY:     jump = flags_i.dirty;
      J_PAGE_MORE: jump = flags_i.page_more;
      default:     jump = 1'b0;
    endcase
  end

  always_comb begin
    case (cw.done_sel)
      D_NO:        done_now = 1'b0;
      D_YES:       done_now = 1'b1;
      D_SYNC_LAST: done_now = flags_i.is_sync && !flags_i.page_more;
      default:     done_now = 1'b0;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (busy_q) begin
      if (cw.emit && done_now) begin
        busy_d = 1'b0;
      end
      pc_d = jump ? cw.target : pc_q + 4'd1;
    end else if (start) begin
      busy_d = 1'b1;
      pc_d   = entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= PC_INVAL;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

  always_comb begin
    ctrl_o.emit   = busy_q && cw.emit;
    ctrl_o.kind   = cw.kind;
    ctrl_o.status = cw.status;
    ctrl_o.done   = done_now;
    ctrl_o.act    = busy_q ? cw.act : A_NONE;
  end

  assign busy = busy_q;

  `FSWB_ASSERT_SAME(a_pc_in_program, busy_q, pc_q <= PC_LAST)
  `FSWB_ASSERT_NEXT(a_start_takes, start && !busy_q, busy_q)
  `FSWB_ASSERT_NEXT(a_busy_holds, busy_q && !(cw.emit && done_now), busy_q)

endmodule

### src/fswb_dp.sv
`include "flash_sector_write_back_block_cache_top_macros.svh"

module fswb_dp
  import fswb_pkg::*;
#(
  parameter int unsigned BLOCK_BYTES  = BLOCK_BYTES_DEF,
  parameter int unsigned SECTOR_BYTES = SECTOR_BYTES_DEF,
  parameter int unsigned PAGE_BYTES   = PAGE_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        accept_i,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] sector_number_i,
  input  ctrl_t       ctrl_i,
  output flags_t      flags_o,
  output logic        out_valid_o,
  output logic [3:0]  cmd_kind_o,
  output logic [31:0] flash_address_o,
  output logic [11:0] cache_offset_o,
  output logic [12:0] byte_length_o,
  output logic [31:0] card_sector_o,
  output logic        status_o,
  output logic        request_done_o
);

  localparam int unsigned LB = $clog2(BLOCK_BYTES);
  localparam int unsigned LS = $clog2(SECTOR_BYTES);
  localparam int unsigned LP = $clog2(PAGE_BYTES);
  localparam int unsigned TW = 32 - LB;
  localparam int unsigned NP = BLOCK_BYTES / PAGE_BYTES;
  localparam int unsigned PW = (NP > 1) ? $clog2(NP) : 1;
  localparam logic [PW-1:0] PageLast = PW'(NP - 1);
  localparam logic [31:0] BlkMask   = 32'(BLOCK_BYTES - 1);
  localparam logic [31:0] BlockLen  = 32'(BLOCK_BYTES);
  localparam logic [31:0] SectorLen = 32'(SECTOR_BYTES);
  localparam logic [31:0] PageLen   = 32'(PAGE_BYTES);

  logic [31:0]   base_q;
  logic          sd_q;
  logic [31:0]   addr_q;
  logic [31:0]   sector_q;
  logic          sync_q;
  logic [TW-1:0] tag_q;
  logic          valid_q, dirty_q;
  logic [PW-1:0] page_q;

  logic [31:0] sec_off;
  logic [31:0] tag_base, blk_base, page_off, sec_in_blk;

  logic        out_valid_q;
  logic [3:0]  kind_q;
  logic [31:0] faddr_q;
  logic [11:0] coff_q;
  logic [12:0] blen_q;
  logic [31:0] card_q;
  logic        status_q, done_q;

  assign sec_off    = sector_number_i << LS;
  assign tag_base   = {tag_q, {LB{1'b0}}};
  assign blk_base   = {addr_q[31:LB], {LB{1'b0}}};
  assign page_off   = 32'(page_q) << LP;
  assign sec_in_blk = addr_q & BlkMask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 32'd0;
      sd_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PARTITION_BASE: base_q <= cfg_data_i;
        REG_SD_BACKED:      sd_q   <= cfg_data_i[0];
        default:            base_q <= base_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      addr_q   <= base_q + sec_off;
      sector_q <= sector_number_i;
      sync_q   <= (opcode_i == OP_SYNC);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q   <= '0;
      valid_q <= 1'b0;
      dirty_q <= 1'b0;
      page_q  <= '0;
    end else begin
      case (ctrl_i.act)
        A_CLR_ALL: begin
          valid_q <= 1'b0;
          dirty_q <= 1'b0;
        end
        A_PAGE_CLR: page_q <= '0;
        A_PAGE_INC: begin
          page_q <= (page_q == PageLast) ? '0 : page_q + PW'(1);
          if (page_q == PageLast) begin
            dirty_q <= 1'b0;
          end
        end
        A_LOAD_TAG: begin
          tag_q   <= addr_q[31:LB];
          valid_q <= 1'b1;
          dirty_q <= 1'b0;
        end
        A_SET_DIRTY: dirty_q <= 1'b1;
        default: tag_q <= tag_q;
      endcase
    end
  end

  always_comb begin
    flags_o.hit       = valid_q && (tag_q == addr_q[31:LB]);
    flags_o.dirty     = valid_q && dirty_q;
    flags_o.page_more = (page_q != PageLast);
    flags_o.is_sync   = sync_q;
    flags_o.sd        = sd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      kind_q      <= K_STATUS;
      faddr_q     <= 32'd0;
      coff_q      <= 12'd0;
      blen_q      <= 13'd0;
      card_q      <= 32'd0;
      status_q    <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      out_valid_q <= ctrl_i.emit;
      kind_q      <= ctrl_i.emit ? ctrl_i.kind : K_STATUS;
      status_q    <= ctrl_i.emit && ctrl_i.status;
      done_q      <= ctrl_i.emit && ctrl_i.done;
      faddr_q     <= 32'd0;
      coff_q      <= 12'd0;
      blen_q      <= 13'd0;
      card_q      <= 32'd0;
      if (ctrl_i.emit) begin
        case (ctrl_i.kind)
          K_ERASE: begin
            faddr_q <= tag_base;
            blen_q  <= BlockLen[12:0];
          end
          K_PROGRAM: begin
            faddr_q <= tag_base + page_off;
            coff_q  <= page_off[11:0];
            blen_q  <= PageLen[12:0];
          end
          K_LOAD: begin
            faddr_q <= blk_base;
            blen_q  <= BlockLen[12:0];
          end
          K_DIRECT: begin
            faddr_q <= addr_q;
            blen_q  <= SectorLen[12:0];
          end
          K_TOHOST, K_TOCACHE: begin
            faddr_q <= addr_q;
            coff_q  <= sec_in_blk[11:0];
            blen_q  <= SectorLen[12:0];
          end
          K_CARDRD, K_CARDWR: begin
            card_q <= sector_q;
            blen_q <= SectorLen[12:0];
          end
          default: blen_q <= 13'd0;
        endcase
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cmd_kind_o      = kind_q;
  assign flash_address_o = faddr_q;
  assign cache_offset_o  = coff_q;
  assign byte_length_o   = blen_q;
  assign card_sector_o   = card_q;
  assign status_o        = status_q;
  assign request_done_o  = done_q;

  `FSWB_ASSERT_SAME(a_done_marks_word, done_q, out_valid_q)
  `FSWB_ASSERT_SAME(a_error_is_status, status_q, kind_q == K_STATUS)
  `FSWB_ASSERT_NEXT(a_merge_dirties, ctrl_i.act == A_SET_DIRTY, valid_q && dirty_q)

endmodule

### src/flash_sector_write_back_block_cache_top.sv
// The first command word is driven from the output register after up to two microcode
// decision steps that emit nothing, then one word per cycle until the run ends.
// The longest item is a write miss on a dirty block: two decision steps, the erase, the
// sixteen passes of the microcode page-program loop (at the default sizes), the block load
// and the cache copy. Nothing is overlapped between items.
// Results are strobed for one cycle each and the receiver cannot stall them.
// Reset clears the cache tag, valid and dirty bits and both configuration registers.
module flash_sector_write_back_block_cache_top
  import fswb_pkg::*;
#(
  parameter int unsigned BLOCK_BYTES  = BLOCK_BYTES_DEF,
  parameter int unsigned SECTOR_BYTES = SECTOR_BYTES_DEF,
  parameter int unsigned PAGE_BYTES   = PAGE_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  drive_number_i,
  input  logic [31:0] sector_number_i,
  input  logic        last_sector_i,
  output logic        out_valid_o,
  output logic [3:0]  cmd_kind_o,
  output logic [31:0] flash_address_o,
  output logic [11:0] cache_offset_o,
  output logic [12:0] byte_length_o,
  output logic [31:0] card_sector_o,
  output logic        status_o,
  output logic        request_done_o
);

  ctrl_t  ctrl;
  flags_t flags;
  logic   accept;

  // The last-sector marker carries no effect on the command run.
  assign accept = start && !busy && (last_sector_i || !last_sector_i);

  fswb_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .opcode_i       (opcode_i),
    .drive_number_i (drive_number_i),
    .flags_i        (flags),
    .busy           (busy),
    .ctrl_o         (ctrl)
  );

  fswb_dp #(
    .BLOCK_BYTES  (BLOCK_BYTES),
    .SECTOR_BYTES (SECTOR_BYTES),
    .PAGE_BYTES   (PAGE_BYTES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .accept_i        (accept),
    .opcode_i        (opcode_i),
    .sector_number_i (sector_number_i),
    .ctrl_i          (ctrl),
    .flags_o         (flags),
    .out_valid_o     (out_valid_o),
    .cmd_kind_o      (cmd_kind_o),
    .flash_address_o (flash_address_o),
    .cache_offset_o  (cache_offset_o),
    .byte_length_o   (byte_length_o),
    .card_sector_o   (card_sector_o),
    .status_o        (status_o),
    .request_done_o  (request_done_o)
  );

endmodule
